// ===== rtl/gpbc_pkg.sv =====
package gpbc_pkg;

   localparam int PIN_COUNT     = 32;
   localparam int INTERVAL_BITS = 16;
   localparam int PTR_W         = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

   localparam logic [2:0] KIND_SET_DIR   = 3'd0;
   localparam logic [2:0] KIND_SET_LEVEL = 3'd1;
   localparam logic [2:0] KIND_START     = 3'd2;
   localparam logic [2:0] KIND_STOP      = 3'd3;
   localparam logic [2:0] KIND_TICK      = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_PIN   = 2'd1;
   localparam logic [1:0] ST_BAD_VALUE = 2'd2;
   localparam logic [1:0] ST_NO_BLINK  = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  pin;
      logic [2:0]  value;
      logic [15:0] blink_ticks;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] pin_levels;
      logic [31:0] pin_outputs;
   } rsp_payload_type;

   typedef struct packed {
      logic                     phase;
      logic [INTERVAL_BITS-1:0] period;
      logic [INTERVAL_BITS-1:0] countdown;
   } blink_entry_type;

   localparam int ENTRY_W = $bits(blink_entry_type);

endpackage

// ===== rtl/gpbc_ram.sv =====
module gpbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gpio_pin_blink_controller_top.sv =====
// Sequence: set direction, set level, stop and unknown kinds pass through execute and
// done; start blink adds a write state (read-modify-write of its timer entry), and a tick
// sweeps the timer memory's single read port over one pin entry per cycle. A stalled
// earlier response holds the done state until the output register is free. One request
// is taken at a time: a new one waits until the last response is loaded.
// Reset (synchronous): all pins input, level latch zero, no blink active, no response
// pending; the timer memory is not cleared and its entries only act for pins with a blink.
module gpio_pin_blink_controller_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  gpbc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output gpbc_pkg::rsp_payload_type rsp_payload
);
   import gpbc_pkg::*;

   // Sequencer: take a request, execute it (possibly sweeping the timer memory),
   // then hand the response to the output register once that register is free.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_START_WR,
      S_TICK,
      S_DONE
   } state_type;

   state_type              state_ff;
   req_payload_type        cmd_ff;
   logic [1:0]             status_ff;
   logic [PTR_W-1:0]       ptr_ff;
   logic [PIN_COUNT-1:0]   dir_ff;
   logic [PIN_COUNT-1:0]   level_ff;
   logic [PIN_COUNT-1:0]   active_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;

   // Timer memory port signals
   logic                   mem_we;
   logic [PTR_W-1:0]       mem_wr_addr;
   blink_entry_type        mem_wr_entry;
   logic [PTR_W-1:0]       mem_rd_addr;
   logic [ENTRY_W-1:0]     mem_rd_data;
   blink_entry_type        rd_entry;

   logic [PTR_W-1:0]       pin_idx;
   logic                   pin_ok;
   logic [INTERVAL_BITS-1:0] load_raw;
   logic [INTERVAL_BITS-1:0] load_val;
   logic                   out_free;
   logic                   rsp_load;
   logic                   tick_expire;
   blink_entry_type        tick_entry;

   assign rd_entry = blink_entry_type'(mem_rd_data);
   assign pin_idx  = cmd_ff.pin[PTR_W-1:0];
   assign pin_ok   = {1'b0, cmd_ff.pin} < 7'(PIN_COUNT);

   // A zero interval behaves as one tick.
   assign load_raw = INTERVAL_BITS'(cmd_ff.blink_ticks);
   assign load_val = (load_raw == '0) ? INTERVAL_BITS'(1) : load_raw;

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Load the finished response into the output register.
   assign rsp_load = (state_ff == S_DONE) && out_free;

   // Tick update for the entry whose read data arrives this cycle.
   assign tick_expire = (rd_entry.countdown <= INTERVAL_BITS'(1));
   always_comb begin
      tick_entry = rd_entry;
      if (tick_expire) begin
         tick_entry.phase     = !rd_entry.phase;
         tick_entry.countdown = rd_entry.period;
      end else begin
         tick_entry.countdown = rd_entry.countdown - INTERVAL_BITS'(1);
      end
   end

   // Memory access steering. During the sweep, reads and writes never target the same entry
   // in the same cycle: the sweep writes entry n while reading entry n+1.
   always_comb begin
      mem_we       = 1'b0;
      mem_wr_addr  = ptr_ff;
      mem_wr_entry = tick_entry;
      mem_rd_addr  = pin_idx;
      case (state_ff)
         S_EXEC: begin
            mem_rd_addr = (cmd_ff.kind == KIND_TICK) ? '0 : pin_idx;
         end
         S_START_WR: begin
            mem_we              = 1'b1;
            mem_wr_addr         = pin_idx;
            mem_wr_entry.phase  = active_ff[pin_idx] ? rd_entry.phase : 1'b0;
            mem_wr_entry.period = load_val;
            mem_wr_entry.countdown = load_val;
         end
         S_TICK: begin
            mem_we      = active_ff[ptr_ff];
            mem_wr_addr = ptr_ff;
            mem_rd_addr = ptr_ff + PTR_W'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   gpbc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PIN_COUNT)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (ENTRY_W'(mem_wr_entry)),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         ptr_ff       <= '0;
         dir_ff       <= '0;
         level_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise the response when loaded, drop it once the consumer takes it.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_payload;
                  state_ff <= S_EXEC;
               end
            end

            S_EXEC: begin
               if (cmd_ff.kind == KIND_TICK) begin
                  // Entry 0 is being read; start the sweep.
                  status_ff <= ST_OK;
                  ptr_ff    <= '0;
                  state_ff  <= S_TICK;
               end else if (!pin_ok) begin
                  status_ff <= ST_BAD_PIN;
                  state_ff  <= S_DONE;
               end else begin
                  case (cmd_ff.kind)
                     KIND_SET_DIR, KIND_SET_LEVEL: begin
                        // Stop any blink first, then check the value.
                        active_ff[pin_idx] <= 1'b0;
                        state_ff           <= S_DONE;
                        if (cmd_ff.value > 3'd1) begin
                           status_ff <= ST_BAD_VALUE;
                        end else begin
                           status_ff <= ST_OK;
                           if (cmd_ff.kind == KIND_SET_DIR) begin
                              dir_ff[pin_idx] <= cmd_ff.value[0];
                           end else begin
                              level_ff[pin_idx] <= cmd_ff.value[0];
                           end
                        end
                     end
                     KIND_START: begin
                        status_ff <= ST_OK;
                        state_ff  <= S_START_WR;
                     end
                     KIND_STOP: begin
                        state_ff <= S_DONE;
                        if (active_ff[pin_idx]) begin
                           active_ff[pin_idx] <= 1'b0;
                           status_ff          <= ST_OK;
                        end else begin
                           status_ff <= ST_NO_BLINK;
                        end
                     end
                     default: begin
                        status_ff <= ST_BAD_VALUE;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end

            S_START_WR: begin
               active_ff[pin_idx] <= 1'b1;
               state_ff           <= S_DONE;
            end

            S_TICK: begin
               // At expiry the new phase drives the pin's level latch.
               if (active_ff[ptr_ff] && tick_expire) begin
                  level_ff[ptr_ff] <= !rd_entry.phase;
               end
               if (ptr_ff == PTR_W'(PIN_COUNT - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  ptr_ff <= ptr_ff + PTR_W'(1);
               end
            end

            S_DONE: begin
               // Hold here until the output register can take the response.
               if (out_free) begin
                  rsp_payload_ff.status      <= status_ff;
                  rsp_payload_ff.pin_levels  <= 32'(level_ff);
                  rsp_payload_ff.pin_outputs <= 32'(dir_ff);
                  state_ff                   <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A new request is taken in idle even while the last response still waits.
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The timer memory is never written while the sequencer is idle or finishing.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_we)
      else $error("timer memory written outside a command");

   // A response is only ever raised from the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside finishing state");

   // A finished start leaves the pin blinking.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_START_WR |=> active_ff[$past(pin_idx)])
      else $error("start did not activate blink");

   // The sweep only writes back entries of blinking pins.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK && mem_we) |-> active_ff[mem_wr_addr])
      else $error("tick wrote an idle pin entry");

   // An accepted request is executed in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_EXEC)
      else $error("accepted request not executed");

endmodule
